// ===== hw/rtl/fir_dec3_pkg.sv =====
// Shared constants, types and the tap weight table for the decimate-by-three FIR.
`timescale 1ns / 1ps
`default_nettype none

package fir_dec3_pkg;

  localparam int TAPS           = 63;
  localparam int WEIGHT_BITS    = 18;
  localparam int SAMPLE_BITS    = 16;
  localparam int DECIMATION     = 3;
  localparam int DIGIT_BITS     = 4;
  localparam int NUM_DIGITS     = SAMPLE_BITS / DIGIT_BITS;
  localparam int ADDR_BITS      = $clog2(TAPS);
  localparam int DIGIT_CNT_BITS = $clog2(NUM_DIGITS);
  localparam int PHASE_BITS     = $clog2(DECIMATION);
  localparam int ACC_BITS       = SAMPLE_BITS + WEIGHT_BITS + $clog2(TAPS);
  localparam int PROD_BITS      = DIGIT_BITS + 1 + WEIGHT_BITS;
  localparam int QUOT_BITS      = ACC_BITS + 2 - WEIGHT_BITS;

  localparam int CUTOFF_HZ    = 7200;
  localparam int HIGH_RATE_HZ = 48000;

  localparam longint          Q30_ONE         = 64'sd1073741824;
  localparam longint          PI_Q30          = 64'sd3373259426;
  localparam longint unsigned HALF_PI_Q30     = 64'd1686629713;
  localparam longint          BLACKMAN_A0_Q30 = 64'sd450971566;
  localparam longint          BLACKMAN_A2_Q30 = 64'sd85899346;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_MAC,
    ST_ROUND,
    ST_EMIT
  } state_e;

  typedef logic signed [WEIGHT_BITS-1:0] weight_t;
  typedef weight_t weight_table_t [TAPS];

  // unsigned quotient by shift and subtract; only used while building the table
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    logic [64:0]     rem;
    longint unsigned quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // num / den, ties away from zero; den > 0
  function automatic longint div_round(input longint num, input longint den);
    longint unsigned mag;
    longint unsigned quo;
    mag = unsigned'((num < 0) ? -num : num);
    quo = udiv(mag + unsigned'(den >>> 1), unsigned'(den));
    return (num < 0) ? -signed'(quo) : signed'(quo);
  endfunction

  // num/den of a turn as a Q32 angle
  function automatic logic [31:0] turn_frac(input longint unsigned num,
                                            input longint unsigned den);
    longint unsigned r;
    r = num - udiv(num, den) * den;
    return 32'(udiv((r << 32) + (den >> 1), den));
  endfunction

  // sin(2*pi*turn/2^32) in Q30, Taylor series on the first quadrant
  function automatic longint sin_q30(input logic [31:0] turn);
    longint unsigned r;
    longint unsigned a;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned dv;
    longint acc;
    r = 64'(turn[29:0]);
    if (turn[30]) r = 64'h4000_0000 - r;
    a = (r * HALF_PI_Q30 + (64'd1 << 29)) >> 30;
    x2 = (a * a + (64'd1 << 29)) >> 30;
    term = a;
    acc = signed'(a);
    for (int i = 1; i <= 7; i++) begin
      dv = 64'((2 * i) * (2 * i + 1));
      term = udiv((term * x2) >> 30, dv);
      if ((i & 1) != 0) acc = acc - signed'(term);
      else acc = acc + signed'(term);
    end
    return turn[31] ? -acc : acc;
  endfunction

  // Blackman-windowed sinc, normalized to unit sum; the div_round steps round half away from zero
  function automatic weight_table_t build_weights();
    weight_table_t tbl;
    longint raw [TAPS];
    longint total;
    longint p2;
    longint ap;
    longint h;
    longint s;
    longint c1;
    longint c2;
    longint w;
    total = 0;
    for (int n = 0; n < TAPS; n++) begin
      p2 = 2 * longint'(n) - longint'(TAPS - 1);
      ap = (p2 < 0) ? -p2 : p2;
      if (ap == 0) begin
        h = div_round(2 * longint'(CUTOFF_HZ) * Q30_ONE, longint'(HIGH_RATE_HZ));
      end else begin
        s = sin_q30(turn_frac(unsigned'(longint'(CUTOFF_HZ) * ap),
                              unsigned'(longint'(2 * HIGH_RATE_HZ))));
        h = div_round(s * 2 * Q30_ONE, PI_Q30 * ap);
      end
      c1 = sin_q30(turn_frac(unsigned'(longint'(n)), unsigned'(longint'(TAPS - 1)))
                   + 32'h4000_0000);
      c2 = sin_q30(turn_frac(unsigned'(longint'(2 * n)), unsigned'(longint'(TAPS - 1)))
                   + 32'h4000_0000);
      w = div_round(BLACKMAN_A0_Q30 * Q30_ONE - c1 * (Q30_ONE >>> 1)
                    + BLACKMAN_A2_Q30 * c2, Q30_ONE);
      raw[n] = div_round(h * w, Q30_ONE);
      total = total + raw[n];
    end
    for (int n = 0; n < TAPS; n++) begin
      if (total > 0) begin
        tbl[n] = WEIGHT_BITS'(div_round(raw[n] * (longint'(1) <<< (WEIGHT_BITS - 1)),
                                        total));
      end else begin
        tbl[n] = (n == 0) ? WEIGHT_BITS'(longint'(1) <<< (WEIGHT_BITS - 1)) : '0;
      end
    end
    return tbl;
  endfunction

  localparam weight_table_t TAP_WEIGHTS = build_weights();

endpackage

`default_nettype wire

// ===== hw/rtl/fir_decimate_by_three.sv =====
// Decimate-by-three FIR / passthrough for 16-bit PCM with a digit-serial MAC.
`timescale 1ns / 1ps
`default_nettype none

// Stream in signed 16-bit samples (tuser = 1 clears history and phase). With
// rate_select = 0 every sample is taken into the result register and then offered
// unchanged from the output register. With rate_select = 1 (reset value) samples go
// into a 63-entry history; two of three are only written there, the third starts a
// filter pass: each tap takes one history read, one load and a 4-bit-by-18-bit
// multiply-accumulate for each of the four sample digits, all through the single
// shared digit multiplier and the single history read port. The input is blocked
// during that pass; a finished result waits in the output register while the next
// sample is taken. History is cleared at reset and by a clear item through per-entry
// valid bits, with no clearing pass. Write rate_select only while idle.
module fir_decimate_by_three (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_wdata_i,      // rate_select
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [fir_dec3_pkg::SAMPLE_BITS-1:0] s_axis_tdata_i,   // [15:0] sample_in
  input  logic                                 s_axis_tuser_i,   // [0] kind
  input  logic                                 s_axis_tlast_i,   // last_in_buffer
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [fir_dec3_pkg::SAMPLE_BITS-1:0] m_axis_tdata_o,   // [15:0] sample_out
  output logic                                 m_axis_tlast_o    // buffer_end
);

  localparam int SB = fir_dec3_pkg::SAMPLE_BITS;
  localparam int AB = fir_dec3_pkg::ADDR_BITS;
  localparam int CB = fir_dec3_pkg::ACC_BITS;
  localparam int DB = fir_dec3_pkg::DIGIT_BITS;
  localparam int QB = fir_dec3_pkg::QUOT_BITS;

  fir_dec3_pkg::state_e state_q, state_d;

  logic                                  rate_q;
  logic [AB-1:0]                         pos_q, pos_d, pos_next;
  logic [fir_dec3_pkg::PHASE_BITS-1:0]   phase_q, phase_d;
  logic [fir_dec3_pkg::TAPS-1:0]         valid_q, valid_d;
  logic [SB-1:0]                         hist_mem [fir_dec3_pkg::TAPS];
  logic [SB-1:0]                         rd_data_q;
  logic                                  rd_valid_q;
  logic [AB-1:0]                         tap_q, tap_d;
  logic [AB-1:0]                         addr_q, addr_d;
  fir_dec3_pkg::weight_t                 weight_q, weight_d;
  logic [SB-1:0]                         dig_q, dig_d;
  logic [fir_dec3_pkg::DIGIT_CNT_BITS-1:0] dcnt_q, dcnt_d;
  logic signed [CB-1:0]                  acc_q, acc_d;
  logic [SB-1:0]                         res_q, res_d;
  logic                                  res_last_q, res_last_d;
  logic                                  out_valid_q, out_valid_d;
  logic [SB-1:0]                         out_data_q, out_data_d;
  logic                                  out_last_q, out_last_d;

  logic in_xfer, is_clear, hist_wr, produce, slot_free, emit;
  logic last_digit, last_tap;
  logic signed [DB:0]                           digit_ext;
  logic signed [fir_dec3_pkg::PROD_BITS-1:0]    prod;
  logic signed [CB-1:0]                         prod_ext;
  logic signed [CB:0]                           biased;
  logic signed [QB-1:0]                         quot;
  logic                                         fits;
  logic [SB-1:0]                                sat_val;

  assign in_xfer   = s_axis_tvalid_i & s_axis_tready_o;
  assign is_clear  = s_axis_tuser_i;
  assign hist_wr   = in_xfer & ~is_clear & rate_q;
  assign produce   = hist_wr & (phase_q == fir_dec3_pkg::PHASE_BITS'(fir_dec3_pkg::DECIMATION - 1));
  assign slot_free = ~out_valid_q | m_axis_tready_i;
  assign pos_next  = (pos_q == AB'(fir_dec3_pkg::TAPS - 1)) ? '0 : pos_q + AB'(1);
  assign last_digit = (dcnt_q == fir_dec3_pkg::DIGIT_CNT_BITS'(fir_dec3_pkg::NUM_DIGITS - 1));
  assign last_tap   = (tap_q == AB'(fir_dec3_pkg::TAPS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fir_dec3_pkg::ST_IDLE: begin
        if (in_xfer && !is_clear && !rate_q) state_d = fir_dec3_pkg::ST_EMIT;
        else if (produce) state_d = fir_dec3_pkg::ST_READ;
      end
      fir_dec3_pkg::ST_READ:  state_d = fir_dec3_pkg::ST_LOAD;
      fir_dec3_pkg::ST_LOAD:  state_d = fir_dec3_pkg::ST_MAC;
      fir_dec3_pkg::ST_MAC: begin
        if (last_digit) state_d = last_tap ? fir_dec3_pkg::ST_ROUND : fir_dec3_pkg::ST_READ;
      end
      fir_dec3_pkg::ST_ROUND: state_d = fir_dec3_pkg::ST_EMIT;
      fir_dec3_pkg::ST_EMIT: begin
        if (slot_free) state_d = fir_dec3_pkg::ST_IDLE;
      end
      default: state_d = fir_dec3_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    emit            = 1'b0;
    case (state_q)
      fir_dec3_pkg::ST_IDLE: s_axis_tready_o = 1'b1;
      fir_dec3_pkg::ST_EMIT: emit = slot_free;
      default: begin
        s_axis_tready_o = 1'b0;
        emit            = 1'b0;
      end
    endcase
  end

  // one digit of the sample times the full weight; top digit carries the sign
  always_comb begin
    if (last_digit) digit_ext = {dig_q[DB-1], dig_q[DB-1:0]};
    else digit_ext = {1'b0, dig_q[DB-1:0]};
    prod     = digit_ext * weight_q;
    prod_ext = CB'(prod);
    prod_ext = prod_ext <<< (DB * dcnt_q);
  end

  // round half away from zero, then saturate
  always_comb begin
    biased = {acc_q[CB-1], acc_q}
             + (CB + 1)'(longint'(1) <<< (fir_dec3_pkg::WEIGHT_BITS - 2))
             - (CB + 1)'(acc_q[CB-1]);
    quot   = biased[CB:fir_dec3_pkg::WEIGHT_BITS-1];
    fits   = (quot[QB-1:SB-1] == '0) || (quot[QB-1:SB-1] == '1);
    sat_val = fits ? quot[SB-1:0] : {quot[QB-1], {(SB - 1){~quot[QB-1]}}};
  end

  always_comb begin
    pos_d       = pos_q;
    phase_d     = phase_q;
    valid_d     = valid_q;
    tap_d       = tap_q;
    addr_d      = addr_q;
    weight_d    = weight_q;
    dig_d       = dig_q;
    dcnt_d      = dcnt_q;
    acc_d       = acc_q;
    res_d       = res_q;
    res_last_d  = res_last_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;

    if (in_xfer && is_clear) begin
      pos_d   = '0;
      phase_d = '0;
      valid_d = '0;
    end
    if (in_xfer && !is_clear && !rate_q) begin
      res_d      = s_axis_tdata_i;
      res_last_d = s_axis_tlast_i;
    end
    if (hist_wr) begin
      pos_d            = pos_next;
      valid_d[pos_next] = 1'b1;
      phase_d          = produce ? '0 : phase_q + fir_dec3_pkg::PHASE_BITS'(1);
    end
    if (produce) begin
      res_last_d = s_axis_tlast_i;
      tap_d      = '0;
      addr_d     = pos_next;
      acc_d      = '0;
    end

    case (state_q)
      fir_dec3_pkg::ST_READ: weight_d = fir_dec3_pkg::TAP_WEIGHTS[tap_q];
      fir_dec3_pkg::ST_LOAD: begin
        dig_d  = rd_valid_q ? rd_data_q : '0;
        dcnt_d = '0;
      end
      fir_dec3_pkg::ST_MAC: begin
        acc_d  = acc_q + prod_ext;
        dig_d  = dig_q >> DB;
        dcnt_d = dcnt_q + fir_dec3_pkg::DIGIT_CNT_BITS'(1);
        if (last_digit && !last_tap) begin
          tap_d  = tap_q + AB'(1);
          addr_d = (addr_q == '0) ? AB'(fir_dec3_pkg::TAPS - 1) : addr_q - AB'(1);
        end
      end
      fir_dec3_pkg::ST_ROUND: res_d = sat_val;
      default: ;
    endcase

    if (m_axis_tready_i) out_valid_d = 1'b0;
    if (emit) begin
      out_valid_d = 1'b1;
      out_data_d  = res_q;
      out_last_d  = res_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fir_dec3_pkg::ST_IDLE;
      rate_q      <= 1'b1;
      pos_q       <= '0;
      phase_q     <= '0;
      valid_q     <= '0;
      tap_q       <= '0;
      addr_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) rate_q <= cfg_wdata_i;
      pos_q       <= pos_d;
      phase_q     <= phase_d;
      valid_q     <= valid_d;
      tap_q       <= tap_d;
      addr_q      <= addr_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    weight_q   <= weight_d;
    dig_q      <= dig_d;
    acc_q      <= acc_d;
    res_q      <= res_d;
    res_last_q <= res_last_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  // history memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (hist_wr) hist_mem[pos_next] <= s_axis_tdata_i;
    if (state_q == fir_dec3_pkg::ST_READ) begin
      rd_data_q  <= hist_mem[addr_q];
      rd_valid_q <= valid_q[addr_q];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tap_q <= AB'(fir_dec3_pkg::TAPS - 1) && pos_q <= AB'(fir_dec3_pkg::TAPS - 1))
    else $error("tap or history index out of range");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q < fir_dec3_pkg::PHASE_BITS'(fir_dec3_pkg::DECIMATION))
    else $error("phase counter out of range");

  a_pass_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    produce |=> state_q == fir_dec3_pkg::ST_READ && tap_q == '0 && acc_q == '0)
    else $error("filter pass did not start clean");

  a_round_after_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fir_dec3_pkg::ST_ROUND |->
      $past(state_q) == fir_dec3_pkg::ST_MAC && $past(last_tap) && $past(last_digit))
    else $error("rounding before the last tap was accumulated");

  a_emit_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q && state_q == fir_dec3_pkg::ST_IDLE)
    else $error("result not moved to output register");
`endif

endmodule

`default_nettype wire

// ===== test/fir_decimate_by_three_tb.sv =====
// Self-checking testbench for the decimate-by-three FIR and its passthrough mode.
`timescale 1ns / 1ps

module fir_decimate_by_three_tb;

  localparam int PCM_BITS = fir_dec3_pkg::SAMPLE_BITS;
  localparam int NTAPS    = 63;
  localparam int WBITS    = 18;
  localparam int DEC      = 3;
  localparam int CUT_HZ   = 7200;
  localparam int FS_HZ    = 48000;
  localparam int SETTLE   = 8;
  localparam int LIMIT    = 4_000_000;

  localparam longint          Q30     = 64'sd1073741824;
  localparam longint          PI_Q    = 64'sd3373259426;
  localparam longint unsigned HALF_PI = 64'd1686629713;
  localparam longint          BL_A0   = 64'sd450971566;
  localparam longint          BL_A2   = 64'sd85899346;

  typedef enum logic {KIND_PCM = 1'b0, KIND_CLEAR = 1'b1} item_kind_e;
  typedef enum logic {RATE_PASS = 1'b0, RATE_DEC3 = 1'b1} rate_e;

  typedef struct packed {
    item_kind_e          kind;
    logic [PCM_BITS-1:0] smp;
    logic                last;
  } pcm_item_t;

  typedef struct packed {
    logic [PCM_BITS-1:0] smp;
    logic                last;
  } pcm_res_t;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                cfg_we    = 1'b0;
  logic                cfg_wdata = 1'b0;
  logic                s_valid   = 1'b0;
  logic                s_ready;
  logic [PCM_BITS-1:0] s_data    = '0;
  logic                s_user    = 1'b0;
  logic                s_last    = 1'b0;
  logic                m_valid;
  logic                m_ready   = 1'b0;
  logic [PCM_BITS-1:0] m_data;
  logic                m_last;

  // predictor state
  longint                     tap_w [NTAPS];
  logic signed [PCM_BITS-1:0] hist_pcm [NTAPS] = '{default: '0};
  int                         hist_pos  = 0;
  int                         dec_phase = 0;
  rate_e                      rate_sel  = RATE_DEC3;

  pcm_item_t pcm_pending [$];
  pcm_res_t  pcm_expected [$];
  pcm_item_t drv_item;
  pcm_res_t  want;

  bit  no_idle   = 1'b0;
  int  hold_req  = 0;
  int  hold_seen = 0;
  int  hold_len  = 0;
  int  hold_left = 0;
  int  n_in      = 0;
  int  n_clear   = 0;
  int  n_out     = 0;
  int  n_sat     = 0;
  int  n_err     = 0;
  int  n_cyc     = 0;

  logic [PCM_BITS-1:0] pcm_edge [5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};

  always #1 clk_i = ~clk_i;

  fir_decimate_by_three u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  // num / den, ties away from zero; den > 0
  function automatic longint round_div(input longint num, input longint den);
    longint unsigned mag;
    longint unsigned d;
    longint unsigned q;
    d   = den;
    mag = (num < 0) ? -num : num;
    q   = (mag + d / 2) / d;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  // num/den of a turn as a Q32 angle
  function automatic logic [31:0] turn_q32(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned r;
    r = num % den;
    return 32'(((r << 32) + den / 2) / den);
  endfunction

  function automatic longint sin_q30(input logic [31:0] turn);
    longint unsigned r;
    longint unsigned a;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    r = {34'd0, turn[29:0]};
    if (turn[30]) r = 64'h4000_0000 - r;
    a    = (r * HALF_PI + (64'd1 << 29)) >> 30;
    x2   = (a * a + (64'd1 << 29)) >> 30;
    term = a;
    acc  = longint'(a);
    for (int i = 1; i <= 7; i++) begin
      term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
      if (i % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    return turn[31] ? -acc : acc;
  endfunction

  task automatic build_tap_weights();
    longint raw [NTAPS];
    longint total;
    longint ap;
    longint h;
    longint s;
    longint c1;
    longint c2;
    longint win;
    total = 0;
    for (int n = 0; n < NTAPS; n++) begin
      ap = 2 * n - (NTAPS - 1);
      if (ap < 0) ap = -ap;
      if (ap == 0) begin
        h = round_div(2 * CUT_HZ * Q30, FS_HZ);
      end else begin
        s = sin_q30(turn_q32(CUT_HZ * ap, 2 * FS_HZ));
        h = round_div(s * 2 * Q30, PI_Q * ap);
      end
      c1     = sin_q30(turn_q32(n, NTAPS - 1) + 32'h4000_0000);
      c2     = sin_q30(turn_q32(2 * n, NTAPS - 1) + 32'h4000_0000);
      win    = round_div(BL_A0 * Q30 - c1 * (Q30 / 2) + BL_A2 * c2, Q30);
      raw[n] = round_div(h * win, Q30);
      total  = total + raw[n];
    end
    for (int n = 0; n < NTAPS; n++) begin
      if (total > 0) tap_w[n] = round_div(raw[n] * (64'sd1 <<< (WBITS - 1)), total);
      else tap_w[n] = (n == 0) ? (64'sd1 <<< (WBITS - 1)) : 0;
    end
  endtask

  task automatic predict_pcm(input item_kind_e kind, input logic [PCM_BITS-1:0] smp,
                             input logic last);
    longint   acc;
    longint   v;
    pcm_res_t r;
    if (kind == KIND_CLEAR) begin
      foreach (hist_pcm[i]) hist_pcm[i] = '0;
      hist_pos  = 0;
      dec_phase = 0;
    end else if (rate_sel == RATE_PASS) begin
      r.smp  = smp;
      r.last = last;
      pcm_expected.push_back(r);
    end else begin
      hist_pos           = (hist_pos + 1) % NTAPS;
      hist_pcm[hist_pos] = smp;
      dec_phase++;
      if (dec_phase >= DEC) begin
        dec_phase = 0;
        acc = 0;
        for (int t = 0; t < NTAPS; t++)
          acc += longint'(hist_pcm[(hist_pos + NTAPS - t) % NTAPS]) * tap_w[t];
        v = round_div(acc, 64'sd1 <<< (WBITS - 1));
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        r.smp  = 16'(v);
        r.last = last;
        pcm_expected.push_back(r);
      end
    end
  endtask

  task automatic flag_error(input string msg);
    n_err++;
    if (n_err <= 10) $display("mismatch: %s", msg);
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_ready) begin
        predict_pcm(item_kind_e'(s_user), s_data, s_last);
        n_in++;
        if (s_user == KIND_CLEAR) n_clear++;
      end
      if (!s_valid || s_ready) begin
        if (pcm_pending.size() != 0 && (no_idle || $urandom_range(99) >= 32)) begin
          drv_item = pcm_pending.pop_front();
          s_valid  <= 1'b1;
          s_data   <= drv_item.smp;
          s_user   <= drv_item.kind;
          s_last   <= drv_item.last;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and result check
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready   <= 1'b0;
      hold_left <= 0;
    end else begin
      if (m_valid && m_ready) begin
        if (pcm_expected.size() == 0) begin
          flag_error($sformatf("result %0d / %0d with nothing expected",
                               $signed(m_data), m_last));
        end else begin
          want = pcm_expected.pop_front();
          n_out++;
          if (m_data !== want.smp)
            flag_error($sformatf("result %0d sample_out: expected %0d, got %0d",
                                 n_out, $signed(want.smp), $signed(m_data)));
          if (m_last !== want.last)
            flag_error($sformatf("result %0d buffer_end: expected %0d, got %0d",
                                 n_out, want.last, m_last));
          if (want.smp == 16'h7FFF || want.smp == 16'h8000) n_sat++;
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_ready   <= 1'b0;
      end else if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_left <= hold_len;
        m_ready   <= 1'b0;
      end else begin
        m_ready <= no_idle || ($urandom_range(99) >= 32);
      end
    end
  end

  always @(posedge clk_i) begin
    n_cyc <= n_cyc + 1;
    if (n_cyc >= LIMIT) begin
      $display("[fir_decimate_by_three] ERROR");
      $finish;
    end
  end

  task automatic push_item(input item_kind_e kind, input logic [PCM_BITS-1:0] smp,
                           input logic last);
    pcm_item_t it;
    it.kind = kind;
    it.smp  = smp;
    it.last = last;
    pcm_pending.push_back(it);
  endtask

  // sender drained and all results in, then a settling wait for absorbed items
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pcm_pending.size() != 0 || s_valid || pcm_expected.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_rate(input rate_e rate);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= rate;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    rate_sel  = rate;
  endtask

  task automatic run_phase(input rate_e rate, input int n, input bit steady, input int hold);
    int   added;
    int   sel;
    int   len;
    logic pos;
    wait_idle();
    set_rate(rate);
    no_idle = steady;
    added   = 0;
    while (added < n) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        push_item(KIND_CLEAR, 16'($urandom()), 1'($urandom()));
        added++;
      end else if (sel < 10) begin
        // full window matched to the tap signs: drives the sum into saturation
        pos = 1'($urandom());
        push_item(KIND_CLEAR, 16'($urandom()), 1'b0);
        for (int k = 0; k < NTAPS; k++)
          push_item(KIND_PCM, ((tap_w[NTAPS-1-k] >= 0) == pos) ? 16'h7FFF : 16'h8000,
                    k == NTAPS - 1);
        added += NTAPS + 1;
      end else if (sel < 22) begin
        len = $urandom_range(9, 3);
        for (int k = 0; k < len; k++)
          push_item(KIND_PCM, pcm_edge[$urandom_range(4)], $urandom_range(4) == 0);
        added += len;
      end else if (sel < 32) begin
        len = $urandom_range(9, 3);
        for (int k = 0; k < len; k++)
          push_item(KIND_PCM, 16'($urandom_range(64) - 32), $urandom_range(4) == 0);
        added += len;
      end else begin
        len = $urandom_range(12, 3);
        for (int k = 0; k < len; k++)
          push_item(KIND_PCM, 16'($urandom()), $urandom_range(4) == 0);
        added += len;
      end
    end
    if (hold != 0) begin
      hold_len = hold;
      hold_req++;
    end
    wait_idle();
    no_idle = 1'b0;
  endtask

  initial begin
    build_tap_weights();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // passthrough: field extremes, alternating bits, clear in this mode
    set_rate(RATE_PASS);
    push_item(KIND_PCM, 16'h7FFF, 1'b1);
    push_item(KIND_PCM, 16'h8000, 1'b0);
    push_item(KIND_PCM, 16'h0000, 1'b1);
    push_item(KIND_PCM, 16'hFFFF, 1'b0);
    push_item(KIND_PCM, 16'h5555, 1'b1);
    push_item(KIND_PCM, 16'hAAAA, 1'b0);
    push_item(KIND_CLEAR, 16'h1234, 1'b1);
    wait_idle();

    // decimate: full-scale steps, buffer mark on an absorbed sample, clear mid-phase
    set_rate(RATE_DEC3);
    push_item(KIND_CLEAR, 16'hFFFF, 1'b0);
    push_item(KIND_PCM, 16'h7FFF, 1'b0);
    push_item(KIND_PCM, 16'h7FFF, 1'b0);
    push_item(KIND_PCM, 16'h7FFF, 1'b1);
    push_item(KIND_PCM, 16'h8000, 1'b1);
    push_item(KIND_PCM, 16'h8000, 1'b0);
    push_item(KIND_PCM, 16'h8000, 1'b0);
    push_item(KIND_PCM, 16'h0001, 1'b0);
    push_item(KIND_CLEAR, 16'h0000, 1'b0);
    push_item(KIND_PCM, 16'h0002, 1'b0);
    push_item(KIND_PCM, 16'h0003, 1'b0);
    push_item(KIND_PCM, 16'h0004, 1'b1);
    // mode switch with one sample in the phase: history and phase carry over
    push_item(KIND_PCM, 16'h4000, 1'b0);
    wait_idle();
    set_rate(RATE_PASS);
    push_item(KIND_PCM, 16'hC000, 1'b1);
    push_item(KIND_PCM, 16'h0100, 1'b0);
    wait_idle();
    set_rate(RATE_DEC3);
    push_item(KIND_PCM, 16'h2000, 1'b0);
    push_item(KIND_PCM, 16'hE000, 1'b1);

    run_phase(RATE_DEC3, 300, 1'b0, 0);
    run_phase(RATE_PASS, 200, 1'b0, 300);
    run_phase(RATE_DEC3, 350, 1'b1, 0);
    run_phase(RATE_PASS, 150, 1'b0, 0);
    run_phase(RATE_DEC3, 400, 1'b0, 1500);
    run_phase(RATE_DEC3, 300, 1'b0, 0);
    wait_idle();

    $display("covered %0d input transfers (%0d clears) over both rates, %0d results checked",
             n_in, n_clear, n_out);
    $display("%0d results at full scale, %0d mismatches, %0d cycles", n_sat, n_err, n_cyc);
    if (n_err == 0 && pcm_expected.size() == 0) begin
      $display("[fir_decimate_by_three] OK");
    end else begin
      $display("[fir_decimate_by_three] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/fir_dec3_pkg.sv
hw/rtl/fir_decimate_by_three.sv
test/fir_decimate_by_three_tb.sv
